// File: rtl/rmts_pkg.sv
// Shared constants, types and slot helpers for the periodic tick scheduler.
package rmts_pkg;

  // Sizing
  localparam int MAX_TASKS     = 4;
  localparam int JOBS_PER_TASK = 2;
  localparam int WORD_COUNT    = 4;
  localparam int SLOT_COUNT    = MAX_TASKS * JOBS_PER_TASK;

  localparam int TASK_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int POS_W  = (JOBS_PER_TASK > 1) ? $clog2(JOBS_PER_TASK) : 1;
  localparam int CNT_W  = $clog2(JOBS_PER_TASK + 1);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field and port widths
  localparam int TIME_W     = 32;
  localparam int FIELD_W    = 16;
  localparam int WORD_W     = 48;
  localparam int TC_W       = 3;
  localparam int OUT_TASK_W = 2;
  localparam int PEND_W     = 4;
  localparam int BIT_W      = 5;
  localparam int IN_W       = 8;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_LAST  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVSEL,
    ST_DIV,
    ST_REL,
    ST_RUN_RD,
    ST_RUN_WB,
    ST_CHK,
    ST_CHK_LAST,
    ST_DONE
  } sched_state_t;

  // One job slot as held in the job memory
  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [FIELD_W-1:0] remaining;
  } job_entry_t;

  // Physical slot of position p in task t's ring
  function automatic logic [SLOT_W-1:0] slot_of(input logic [TASK_W-1:0] t,
                                                input logic [POS_W-1:0]  p);
    return SLOT_W'(int'(t) * JOBS_PER_TASK + int'(p));
  endfunction

  // Ring position head + n, wrapped
  function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] head,
                                              input logic [CNT_W-1:0] n);
    int s;
    s = int'(head) + int'(n);
    if (s >= JOBS_PER_TASK) s = s - JOBS_PER_TASK;
    return POS_W'(s);
  endfunction

  // Slot position s holds a pending job of a ring with this head and count
  function automatic logic slot_live(input logic [POS_W-1:0] s,
                                     input logic [POS_W-1:0] head,
                                     input logic [CNT_W-1:0] cnt);
    int off;
    off = int'(s) - int'(head);
    if (off < 0) off = off + JOBS_PER_TASK;
    return off < int'(cnt);
  endfunction

endpackage

// File: rtl/rate_monotonic_tick_scheduler.sv
// Tick scheduler: shortest-period-first execution over up to four periodic tasks.
//
// Usage: each item on the in_ stream is one scheduler tick; in_tdata bit 0 is the
// restart flag, which clears all jobs, the miss latch and the time before the tick
// is processed as tick zero. Every tick gives exactly one item on the out_ stream
// with the tick time, the job that ran, whether it finished, the latched miss and
// the number of pending jobs. Task parameters are written through the cfg_ port
// (index 0 task count, 1..4 task words) while no tick is in flight.
// Timing: a tick goes through the release pass, one unit of the chosen job, if any,
// and the deadline scan before its result is in the output register; the next tick
// is accepted in the cycle after. The release pass (one task a cycle) and the scan
// of the eight job slots on the memory's single read port set a tick's length.
// After a task word is written, the next tick first rebuilds that task's phase
// (time modulo period) with a bit-serial remainder unit, lowest task first.
// Reset clears time, jobs, miss latch, task words (task count 1); no clearing pass.
// A stalled receiver holds the result; one further tick is accepted and worked
// through, then the block waits until the output register is free.
module rate_monotonic_tick_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rmts_pkg::IN_W-1:0]       in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] now_time, [32] ran_valid, [34:33] ran_task, [35] job_finished,
  // [36] miss, [38:37] miss_task, [42:39] pending_count, [47:43] zero
  output logic [rmts_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmts_pkg::WORD_W-1:0]     cfg_wdata
);

  localparam int NT = rmts_pkg::MAX_TASKS;
  localparam int JT = rmts_pkg::JOBS_PER_TASK;

  // Configuration
  logic [rmts_pkg::TC_W-1:0]   tc_r;
  logic [rmts_pkg::WORD_W-1:0] word_r [rmts_pkg::WORD_COUNT];

  // Control and per-task state
  rmts_pkg::sched_state_t      state_r, state_nxt;
  logic [rmts_pkg::TIME_W-1:0] time_now_r, time_now_nxt;
  logic [rmts_pkg::POS_W-1:0]  head_r [NT];
  logic [rmts_pkg::POS_W-1:0]  head_nxt [NT];
  logic [rmts_pkg::CNT_W-1:0]  cnt_r [NT];
  logic [rmts_pkg::CNT_W-1:0]  cnt_nxt [NT];
  logic [rmts_pkg::FIELD_W-1:0] phase_r [NT];
  logic [rmts_pkg::FIELD_W-1:0] phase_nxt [NT];
  logic [NT-1:0]               dirty_r, dirty_nxt;
  logic                        failed_r, failed_nxt;
  logic [rmts_pkg::OUT_TASK_W-1:0] ftask_r, ftask_nxt;
  logic [rmts_pkg::TASK_W-1:0] cur_t_r, cur_t_nxt;
  logic [rmts_pkg::POS_W-1:0]  chk_s_r, chk_s_nxt;
  logic                        chk_v_r, chk_v_nxt;
  logic [rmts_pkg::TASK_W-1:0] chk_t_r, chk_t_nxt;
  logic [rmts_pkg::FIELD_W-1:0] rem_r, rem_nxt;
  logic [rmts_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic                        ran_r, ran_nxt;
  logic [rmts_pkg::TASK_W-1:0] ran_t_r, ran_t_nxt;
  logic                        fin_r, fin_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [rmts_pkg::OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  // Job memory
  rmts_pkg::job_entry_t        job_mem [rmts_pkg::SLOT_COUNT];
  rmts_pkg::job_entry_t        rd_data_r;
  logic                        mem_we, mem_re;
  logic [rmts_pkg::SLOT_W-1:0] mem_waddr, mem_raddr;
  rmts_pkg::job_entry_t        mem_wdata;

  logic                        out_load;

  assign in_tready  = (state_r == rmts_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= rmts_pkg::TC_W'(1);
      for (int i = 0; i < rmts_pkg::WORD_COUNT; i++) word_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rmts_pkg::REG_TASK_COUNT) begin
        tc_r <= cfg_wdata[rmts_pkg::TC_W-1:0];
      end else if (cfg_index >= rmts_pkg::REG_TASK_FIRST &&
                   cfg_index <= rmts_pkg::REG_TASK_LAST) begin
        word_r[2'(cfg_index - rmts_pkg::REG_TASK_FIRST)] <= cfg_wdata;
      end
    end
  end

  // Job memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) job_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= job_mem[mem_raddr];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rmts_pkg::ST_IDLE;
      time_now_r   <= '0;
      dirty_r      <= '0;
      failed_r     <= 1'b0;
      ftask_r      <= '0;
      out_tvalid_r <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        head_r[t]  <= '0;
        cnt_r[t]   <= '0;
        phase_r[t] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      time_now_r   <= time_now_nxt;
      dirty_r      <= dirty_nxt;
      failed_r     <= failed_nxt;
      ftask_r      <= ftask_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur_t_r     <= cur_t_nxt;
    chk_s_r     <= chk_s_nxt;
    chk_v_r     <= chk_v_nxt;
    chk_t_r     <= chk_t_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    ran_r       <= ran_nxt;
    ran_t_r     <= ran_t_nxt;
    fin_r       <= fin_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Sequencer: next state, datapath and memory control
  always_comb begin
    logic [rmts_pkg::WORD_W-1:0]  cur_word;
    logic [rmts_pkg::FIELD_W-1:0] cur_per, cur_exe, cur_rdl, new_rem;
    logic [rmts_pkg::POS_W-1:0]   cur_head;
    logic [rmts_pkg::CNT_W-1:0]   cur_cnt;
    logic [rmts_pkg::TC_W-1:0]    n_use;
    logic [rmts_pkg::FIELD_W:0]   div_sh, ph1;
    logic                         found, any_dirty;
    logic [rmts_pkg::TASK_W-1:0]  best, low_dirty;
    logic [rmts_pkg::FIELD_W-1:0] best_per;
    logic [rmts_pkg::PEND_W-1:0]  pend;
    logic                         last_chk;

    state_nxt      = state_r;
    time_now_nxt   = time_now_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    dirty_nxt      = dirty_r;
    failed_nxt     = failed_r;
    ftask_nxt      = ftask_r;
    cur_t_nxt      = cur_t_r;
    chk_s_nxt      = chk_s_r;
    chk_v_nxt      = chk_v_r;
    chk_t_nxt      = chk_t_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    ran_nxt        = ran_r;
    ran_t_nxt      = ran_t_r;
    fin_nxt        = fin_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = rd_data_r;
    out_load       = 1'b0;
    ph1            = '0;

    // Task under the shared index
    cur_word = word_r[cur_t_r];
    cur_per  = cur_word[15:0];
    cur_exe  = cur_word[31:16];
    cur_rdl  = cur_word[47:32];
    cur_head = head_r[cur_t_r];
    cur_cnt  = cnt_r[cur_t_r];
    n_use    = (tc_r > rmts_pkg::TC_W'(NT)) ? rmts_pkg::TC_W'(NT) : tc_r;

    // Oldest job of the shortest-period task, lower index on ties
    found    = 1'b0;
    best     = '0;
    best_per = '0;
    for (int t = 0; t < NT; t++) begin
      if (cnt_r[t] != '0 && (!found || word_r[t][15:0] < best_per)) begin
        found    = 1'b1;
        best     = rmts_pkg::TASK_W'(t);
        best_per = word_r[t][15:0];
      end
    end

    // Lowest task whose phase must be rebuilt
    any_dirty = 1'b0;
    low_dirty = '0;
    for (int t = NT - 1; t >= 0; t--) begin
      if (dirty_r[t]) begin
        any_dirty = 1'b1;
        low_dirty = rmts_pkg::TASK_W'(t);
      end
    end

    pend = '0;
    for (int t = 0; t < NT; t++) pend = pend + rmts_pkg::PEND_W'(cnt_r[t]);

    // One remainder step: shift in the next time bit, subtract if it fits
    div_sh   = {rem_r, time_now_r[bit_r]};
    new_rem  = (rd_data_r.remaining != '0) ? rd_data_r.remaining - 16'd1 : '0;
    last_chk = (cur_t_r == rmts_pkg::TASK_W'(NT - 1)) &&
               (chk_s_r == rmts_pkg::POS_W'(JT - 1));

    case (state_r)
      rmts_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[0]) begin
            time_now_nxt = '0;
            failed_nxt   = 1'b0;
            ftask_nxt    = '0;
            dirty_nxt    = '0;
            for (int t = 0; t < NT; t++) begin
              head_nxt[t]  = '0;
              cnt_nxt[t]   = '0;
              phase_nxt[t] = '0;
            end
          end
          state_nxt = rmts_pkg::ST_DIVSEL;
        end
      end

      rmts_pkg::ST_DIVSEL: begin
        rem_nxt = '0;
        bit_nxt = rmts_pkg::BIT_W'(rmts_pkg::TIME_W - 1);
        if (any_dirty) begin
          cur_t_nxt = low_dirty;
          state_nxt = rmts_pkg::ST_DIV;
        end else begin
          cur_t_nxt = '0;
          state_nxt = rmts_pkg::ST_REL;
        end
      end

      rmts_pkg::ST_DIV: begin
        if (div_sh >= {1'b0, cur_per}) begin
          rem_nxt = rmts_pkg::FIELD_W'(div_sh - {1'b0, cur_per});
        end else begin
          rem_nxt = div_sh[rmts_pkg::FIELD_W-1:0];
        end
        bit_nxt = bit_r - 5'd1;
        if (bit_r == '0) begin
          phase_nxt[cur_t_r] = (cur_per == '0) ? '0 : rem_nxt;
          dirty_nxt[cur_t_r] = 1'b0;
          state_nxt          = rmts_pkg::ST_DIVSEL;
        end
      end

      // Release, one task a cycle; a full ring raises the miss
      rmts_pkg::ST_REL: begin
        if (rmts_pkg::TC_W'(cur_t_r) < n_use && cur_per != '0 && cur_exe != '0 &&
            phase_r[cur_t_r] == '0) begin
          if (cur_cnt < rmts_pkg::CNT_W'(JT)) begin
            mem_we             = 1'b1;
            mem_waddr          = rmts_pkg::slot_of(cur_t_r,
                                                   rmts_pkg::pos_add(cur_head, cur_cnt));
            mem_wdata.remaining = cur_exe;
            mem_wdata.deadline  = time_now_r + {16'd0, cur_rdl};
            cnt_nxt[cur_t_r]   = cur_cnt + rmts_pkg::CNT_W'(1);
          end else if (!failed_r) begin
            failed_nxt = 1'b1;
            ftask_nxt  = rmts_pkg::OUT_TASK_W'(cur_t_r);
          end
        end
        if (cur_t_r == rmts_pkg::TASK_W'(NT - 1)) begin
          state_nxt = rmts_pkg::ST_RUN_RD;
        end else begin
          cur_t_nxt = cur_t_r + rmts_pkg::TASK_W'(1);
        end
      end

      rmts_pkg::ST_RUN_RD: begin
        ran_nxt   = found;
        ran_t_nxt = best;
        fin_nxt   = 1'b0;
        if (found) begin
          mem_re    = 1'b1;
          mem_raddr = rmts_pkg::slot_of(best, head_r[best]);
          cur_t_nxt = best;
          state_nxt = rmts_pkg::ST_RUN_WB;
        end else begin
          cur_t_nxt = '0;
          chk_s_nxt = '0;
          chk_v_nxt = 1'b0;
          state_nxt = rmts_pkg::ST_CHK;
        end
      end

      // Run one unit; a finished job leaves the head of its ring
      rmts_pkg::ST_RUN_WB: begin
        if (new_rem == '0) begin
          fin_nxt            = 1'b1;
          head_nxt[cur_t_r]  = rmts_pkg::pos_add(cur_head, rmts_pkg::CNT_W'(1));
          cnt_nxt[cur_t_r]   = cur_cnt - rmts_pkg::CNT_W'(1);
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = rmts_pkg::slot_of(cur_t_r, cur_head);
          mem_wdata.remaining = new_rem;
          mem_wdata.deadline  = rd_data_r.deadline;
        end
        cur_t_nxt = '0;
        chk_s_nxt = '0;
        chk_v_nxt = 1'b0;
        state_nxt = rmts_pkg::ST_CHK;
      end

      // Deadline scan in slot order, each slot compared in the cycle after its read
      rmts_pkg::ST_CHK: begin
        if (chk_v_r && rd_data_r.deadline < time_now_r && !failed_r) begin
          failed_nxt = 1'b1;
          ftask_nxt  = rmts_pkg::OUT_TASK_W'(chk_t_r);
        end
        mem_re    = 1'b1;
        mem_raddr = rmts_pkg::slot_of(cur_t_r, chk_s_r);
        chk_v_nxt = rmts_pkg::slot_live(chk_s_r, cur_head, cur_cnt);
        chk_t_nxt = cur_t_r;
        if (last_chk) begin
          state_nxt = rmts_pkg::ST_CHK_LAST;
        end else if (chk_s_r == rmts_pkg::POS_W'(JT - 1)) begin
          chk_s_nxt = '0;
          cur_t_nxt = cur_t_r + rmts_pkg::TASK_W'(1);
        end else begin
          chk_s_nxt = chk_s_r + rmts_pkg::POS_W'(1);
        end
      end

      rmts_pkg::ST_CHK_LAST: begin
        if (chk_v_r && rd_data_r.deadline < time_now_r && !failed_r) begin
          failed_nxt = 1'b1;
          ftask_nxt  = rmts_pkg::OUT_TASK_W'(chk_t_r);
        end
        state_nxt = rmts_pkg::ST_DONE;
      end

      // Hand the result over and step time and phases
      rmts_pkg::ST_DONE: begin
        out_load = !out_tvalid_r || out_tready;
        if (out_load) begin
          out_tdata_nxt = {5'd0, pend, ftask_r, failed_r, fin_r,
                           rmts_pkg::OUT_TASK_W'(ran_t_r), ran_r, time_now_r};
          time_now_nxt  = time_now_r + 32'd1;
          for (int t = 0; t < NT; t++) begin
            ph1 = {1'b0, phase_r[t]} + 17'd1;
            if (time_now_r == '1 || ph1 == {1'b0, word_r[t][15:0]}) begin
              phase_nxt[t] = '0;
            end else begin
              phase_nxt[t] = ph1[rmts_pkg::FIELD_W-1:0];
            end
          end
          state_nxt = rmts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rmts_pkg::ST_IDLE;
      end
    endcase

    // Output handshake
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // A new task word invalidates that task's phase
    if (cfg_we && cfg_index >= rmts_pkg::REG_TASK_FIRST &&
        cfg_index <= rmts_pkg::REG_TASK_LAST) begin
      for (int t = 0; t < NT; t++) begin
        if (cfg_index == rmts_pkg::REG_TASK_FIRST + rmts_pkg::CFG_IDX_W'(t)) begin
          dirty_nxt[t] = 1'b1;
        end
      end
    end
  end

  // Checks
  a_div_only_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rmts_pkg::ST_DIV |-> dirty_r[cur_t_r])
    else $error("remainder unit busy on a task with a valid phase");

  a_run_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rmts_pkg::ST_RUN_WB |-> cnt_r[cur_t_r] != '0)
    else $error("job run on an empty ring");

  a_miss_latched: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !(in_tvalid && in_tready && in_tdata[0]) |=> failed_r)
    else $error("miss latch cleared without restart");

  a_time_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rmts_pkg::ST_DONE && out_load |=>
      time_now_r == $past(time_now_r) + 32'd1)
    else $error("time did not advance by one per tick");

endmodule
